FILE: rtl/core/seq_pkg.sv
// Shared types, constants and codes of the sorted event queue.
package seq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int LEN_W       = 16;
    localparam int TOTAL_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 64;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD    = 2'd0,
        OP_ENQUEUE = 2'd1,
        OP_DEQUEUE = 2'd2
    } op_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_val;
        logic              is_departure;
        logic [LEN_W-1:0]  length;
    } slot_t;

    typedef struct packed {
        op_t               op;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] arrival_time;
        logic [LEN_W-1:0]  service_length;
        logic [TIME_W-1:0] departure_time;
    } cmd_t;

endpackage

FILE: rtl/core/seq_cell.sv
// One queue slot: compare against the arrival and shift with its neighbors.
module seq_cell (
    input  logic                    clk,
    input  seq_pkg::cmd_t           cmd,
    input  logic [seq_pkg::IDX_W-1:0] idx,
    input  seq_pkg::slot_t          left_slot,
    input  logic                    left_le,
    input  seq_pkg::slot_t          right_slot,
    output seq_pkg::slot_t          slot,
    output seq_pkg::slot_t          slot_nxt,
    output logic                    le
);
    import seq_pkg::*;

    slot_t            slot_reg;
    slot_t            slot_next;
    logic [CNT_W-1:0] idx_cnt;
    logic [CNT_W-1:0] tail_idx;
    logic             held;
    logic             is_pos;

    assign idx_cnt  = CNT_W'(idx);
    assign tail_idx = cmd.count + CNT_W'(1);
    assign held     = idx_cnt < cmd.count;
    assign le       = held && (slot_reg.time_val <= cmd.arrival_time);
    assign is_pos   = !le && left_le;

    always_comb
    begin
        slot_next = slot_reg;
        unique case (cmd.op)
            OP_ENQUEUE:
            begin
                if (idx_cnt == tail_idx)
                begin
                    slot_next.time_val     = cmd.departure_time;
                    slot_next.is_departure = 1'b1;
                    slot_next.length       = '0;
                end
                else if (le)
                begin
                    slot_next = slot_reg;
                end
                else if (is_pos)
                begin
                    slot_next.time_val     = cmd.arrival_time;
                    slot_next.is_departure = 1'b0;
                    slot_next.length       = cmd.service_length;
                end
                else
                begin
                    slot_next = left_slot;
                end
            end
            OP_DEQUEUE: slot_next = right_slot;
            default:    slot_next = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot     = slot_reg;
    assign slot_nxt = slot_next;

endmodule

FILE: rtl/core/sorted_event_queue_with_departure_top.sv
// Top level of the sorted event queue: command decode, cell chain and result register.
//  channel | dir | tdata (low bit up)                                   | tuser
//  s_*     | in  | arrival_time[31:0], service_length[47:32]           | action
//  m_*     | out | status[1:0], head_valid[2], head_time[34:3],         | -
//          |     | head_is_departure[35], head_length[51:36],           |
//          |     | entry_total[56:52], zero fill[63:57]                 |
// One item per cycle: every cell shifts, inserts or holds in the same edge.
// The result appears in the cycle after acceptance; the output register lets
// a new item enter while the result is being taken. A stalled result holds
// s_tready low. Reset empties the queue; slot contents are not cleared.
module sorted_event_queue_with_departure_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [seq_pkg::IN_DATA_W-1:0]   s_tdata,  // arrival_time, service_length
    input  logic                            s_tuser,  // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [seq_pkg::OUT_DATA_W-1:0]  m_tdata   // status, head_valid, head_time,
                                                      // head_is_departure, head_length,
                                                      // entry_total
);
    import seq_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [TIME_W-1:0]     tail_reg;
    logic [TIME_W-1:0]     tail_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  fire;
    logic [TIME_W-1:0]     arrival_time;
    logic [LEN_W-1:0]      service_length;
    logic                  full;
    logic [TIME_W-1:0]     base_time;
    logic [TIME_W:0]       dep_sum;
    logic [TIME_W-1:0]     dep_time;
    logic [STATUS_W-1:0]   status;
    cmd_t                  cmd;
    slot_t                 head;

    slot_t                 slots [QUEUE_DEPTH];
    slot_t                 nxts  [QUEUE_DEPTH];
    logic                  les   [QUEUE_DEPTH];

    assign s_tready       = !out_valid_reg || m_tready;
    assign fire           = s_tvalid && s_tready;
    assign arrival_time   = s_tdata[TIME_W-1:0];
    assign service_length = s_tdata[TIME_W +: LEN_W];

    assign full      = ({1'b0, count_reg} + (CNT_W+1)'(2)) > (CNT_W+1)'(QUEUE_DEPTH);
    assign base_time = (count_reg != '0 && tail_reg > arrival_time) ? tail_reg : arrival_time;
    assign dep_sum   = {1'b0, base_time} + (TIME_W+1)'(service_length);
    assign dep_time  = dep_sum[TIME_W] ? {TIME_W{1'b1}} : dep_sum[TIME_W-1:0];

    always_comb
    begin
        cmd.op             = OP_HOLD;
        cmd.count          = count_reg;
        cmd.arrival_time   = arrival_time;
        cmd.service_length = service_length;
        cmd.departure_time = dep_time;
        status             = STATUS_DONE;
        count_next         = count_reg;
        tail_next          = tail_reg;
        if (fire)
        begin
            unique case (s_tuser)
                ACT_ENQUEUE:
                begin
                    if (full)
                    begin
                        status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.op     = OP_ENQUEUE;
                        count_next = count_reg + CNT_W'(2);
                        tail_next  = dep_time;
                    end
                end
                ACT_DEQUEUE:
                begin
                    if (count_reg == '0)
                    begin
                        status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.op     = OP_DEQUEUE;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: status = STATUS_DONE;
            endcase
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        slot_t left_slot;
        slot_t right_slot;
        logic  left_le;

        if (i == 0)
        begin : g_first
            assign left_slot = '0;
            assign left_le   = 1'b1;
        end
        else
        begin : g_inner
            assign left_slot = slots[i-1];
            assign left_le   = les[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_slot = '0;
        end
        else
        begin : g_mid
            assign right_slot = slots[i+1];
        end

        seq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (IDX_W'(i)),
            .left_slot  (left_slot),
            .left_le    (left_le),
            .right_slot (right_slot),
            .slot       (slots[i]),
            .slot_nxt   (nxts[i]),
            .le         (les[i])
        );
    end

    always_comb
    begin
        head = (count_next != '0) ? nxts[0] : '0;
        out_data_next = {
            (OUT_DATA_W - STATUS_W - 1 - TIME_W - 1 - LEN_W - TOTAL_W)'(0),
            TOTAL_W'(count_next),
            head.length,
            head.is_departure,
            head.time_val,
            (count_next != '0),
            status
        };
        out_valid_next = out_valid_reg && !m_tready;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tail_reg <= tail_next;
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/seq_checker.sv
// Port-level checks of the sorted event queue, bound to the top level.
module seq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [seq_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import seq_pkg::*;

    logic [STATUS_W-1:0] status;
    logic                head_valid;
    logic [TIME_W-1:0]   head_time;
    logic [TOTAL_W-1:0]  entry_total;

    assign status      = m_tdata[1:0];
    assign head_valid  = m_tdata[2];
    assign head_time   = m_tdata[34:3];
    assign entry_total = m_tdata[56:52];

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == STATUS_DONE || status == STATUS_FULL || status == STATUS_EMPTY))
        else $error("undefined status code");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (head_valid == (entry_total != '0)))
        else $error("head_valid disagrees with entry_total");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !head_valid) |-> (head_time == '0 && m_tdata[51:35] == '0))
        else $error("empty queue reports a head entry");

    a_empty_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && status == STATUS_EMPTY) |-> (entry_total == '0))
        else $error("empty dequeue refused with entries held");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind sorted_event_queue_with_departure_top seq_checker u_seq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
